// ===== hw/rtl/macs_pkg.sv =====
// shared types, constants and codes of the motor angle calibration sequencer
package macs_pkg;

   localparam int TICKS_PER_CYCLE_DEF = 16;
   localparam int STEPS_PER_TURN_DEF  = 100;

   localparam int SAMPLE_BITS = 12;
   localparam int ANGLE_W     = 7;
   localparam int TIMER_W     = 20;
   localparam int SEQ_W       = 32;
   localparam int MS_W        = 16;
   localparam int PAIRS_W     = 7;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int NUM_CH      = 4;

   localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_MS  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_MS   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_POLE_PAIRS = CSR_IDX_W'(2);

   localparam logic [MS_W-1:0]    SETTLE_MS_RST  = MS_W'(1000);
   localparam logic [MS_W-1:0]    NOISE_MS_RST   = MS_W'(1000);
   localparam logic [PAIRS_W-1:0] POLE_PAIRS_RST = PAIRS_W'(1);

   // item kinds
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // record modes
   localparam logic MODE_NOISE = 1'b0;
   localparam logic MODE_ANGLE = 1'b1;

   typedef enum logic [1:0] {
      PH_SETTLE = 2'd0,
      PH_NOISE  = 2'd1,
      PH_ROTATE = 2'd2,
      PH_IDLE   = 2'd3
   } phase_type;

   typedef struct packed {
      logic                   command;
      logic                   run;
      logic [SAMPLE_BITS-1:0] sin_a;
      logic [SAMPLE_BITS-1:0] cos_a;
      logic [SAMPLE_BITS-1:0] sin_b;
      logic [SAMPLE_BITS-1:0] cos_b;
   } req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]     angle_now;
      logic                   record_valid;
      logic [SEQ_W-1:0]       record_index;
      logic                   record_mode;
      logic [ANGLE_W-1:0]     record_angle;
      logic [SAMPLE_BITS-1:0] rec_sin_a;
      logic [SAMPLE_BITS-1:0] rec_cos_a;
      logic [SAMPLE_BITS-1:0] rec_sin_b;
      logic [SAMPLE_BITS-1:0] rec_cos_b;
   } rsp_type;

endpackage

// ===== hw/rtl/macs_req_stage.sv =====
// input register stage: holds one request beat until the core takes it
module macs_req_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  macs_pkg::req_type req_data,
   input  logic             advance,
   output logic             item_valid,
   output macs_pkg::req_type item
);
   import macs_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;
   logic    load;

   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

// ===== hw/rtl/macs_rsp_stage.sv =====
// result register stage: holds one response beat until downstream takes it
module macs_rsp_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  macs_pkg::rsp_type result,
   output logic             out_free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output macs_pkg::rsp_type rsp_data
);
   import macs_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== hw/rtl/macs_core.sv =====
// sequencer state, sample banks, control registers and result logic
module macs_core #(
   parameter int TICKS_PER_CYCLE = macs_pkg::TICKS_PER_CYCLE_DEF,
   parameter int STEPS_PER_TURN  = macs_pkg::STEPS_PER_TURN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [macs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [macs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            fire,
   input  macs_pkg::req_type               item,
   output macs_pkg::rsp_type               result
);
   import macs_pkg::*;

   localparam int DIV_W = $clog2(TICKS_PER_CYCLE + 1);
   localparam logic [TIMER_W-1:0] ROT_MS = TIMER_W'(TICKS_PER_CYCLE * STEPS_PER_TURN);
   localparam logic [ANGLE_W-1:0] LAST_STEP = ANGLE_W'(STEPS_PER_TURN - 1);
   localparam logic [DIV_W:0] DIV_END = (DIV_W + 1)'(TICKS_PER_CYCLE);

   logic [MS_W-1:0]        settle_ms_ff;
   logic [MS_W-1:0]        noise_ms_ff;
   logic [PAIRS_W-1:0]     pole_pairs_ff;

   phase_type              phase_ff, phase_in;
   logic [DIV_W-1:0]       div_ff, div_in;
   logic [TIMER_W-1:0]     timer_ff, timer_in;
   logic [SEQ_W-1:0]       seq_ff, seq_in;
   logic [ANGLE_W-1:0]     angle_ff, angle_in;
   logic                   bank_ff, bank_in;
   logic [SAMPLE_BITS-1:0] bank0_ff [NUM_CH];
   logic [SAMPLE_BITS-1:0] bank1_ff [NUM_CH];

   logic                   is_tick, acting, run_act, stop_act;
   logic [DIV_W:0]         div_inc;
   logic [TIMER_W-1:0]     timer_inc;
   logic [TIMER_W+PAIRS_W-1:0] rot_limit;
   phase_type              phase_next;
   logic                   emit;
   logic [ANGLE_W-1:0]     angle_next;
   logic [SAMPLE_BITS-1:0] samp [NUM_CH];
   logic [SAMPLE_BITS-1:0] rd   [NUM_CH];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ms_ff  <= SETTLE_MS_RST;
         noise_ms_ff   <= NOISE_MS_RST;
         pole_pairs_ff <= POLE_PAIRS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SETTLE_MS:  settle_ms_ff  <= csr_wdata;
            CSR_NOISE_MS:   noise_ms_ff   <= csr_wdata;
            CSR_POLE_PAIRS: pole_pairs_ff <= csr_wdata[PAIRS_W-1:0];
            default: ;
         endcase
      end
   end

   assign is_tick   = (item.command == CMD_TICK);
   assign div_inc   = {1'b0, div_ff} + (DIV_W + 1)'(1);
   assign acting    = is_tick && (div_inc == DIV_END);
   assign run_act   = acting && item.run;
   assign stop_act  = acting && !item.run;
   assign timer_inc = (timer_ff != TIMER_MAX) ? timer_ff + TIMER_W'(1) : timer_ff;
   assign rot_limit = {{PAIRS_W{1'b0}}, ROT_MS} * {{TIMER_W{1'b0}}, pole_pairs_ff};

   // next phase, judged on the incremented timer
   always_comb begin
      phase_next = phase_ff;
      case (phase_ff)
         PH_SETTLE: begin
            if (timer_inc >= TIMER_W'(settle_ms_ff)) phase_next = PH_NOISE;
         end
         PH_NOISE: begin
            if (timer_inc >= TIMER_W'(noise_ms_ff)) phase_next = PH_ROTATE;
         end
         PH_ROTATE: begin
            if ({{PAIRS_W{1'b0}}, timer_inc} >= rot_limit) phase_next = PH_IDLE;
         end
         default: phase_next = phase_ff;
      endcase
   end

   // phase outputs: record emission and angle advance
   always_comb begin
      emit       = 1'b0;
      angle_next = angle_ff;
      case (phase_ff)
         PH_NOISE: begin
            emit = 1'b1;
         end
         PH_ROTATE: begin
            emit       = 1'b1;
            angle_next = (angle_ff >= LAST_STEP) ? '0 : angle_ff + ANGLE_W'(1);
         end
         default: begin
            emit       = 1'b0;
            angle_next = angle_ff;
         end
      endcase
   end

   assign samp[0] = item.sin_a;
   assign samp[1] = item.cos_a;
   assign samp[2] = item.sin_b;
   assign samp[3] = item.cos_b;

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         rd[i] = bank_ff ? bank1_ff[i] : bank0_ff[i];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      div_in   = div_ff;
      timer_in = timer_ff;
      seq_in   = seq_ff;
      angle_in = angle_ff;
      bank_in  = bank_ff;
      if (is_tick) begin
         div_in   = acting ? '0 : div_inc[DIV_W-1:0];
         timer_in = timer_inc;
         if (stop_act) begin
            phase_in = PH_SETTLE;
            seq_in   = '0;
            timer_in = '0;
            angle_in = '0;
         end else if (run_act) begin
            angle_in = angle_next;
            if (phase_next != phase_ff) begin
               phase_in = phase_next;
               timer_in = '0;
            end
            if (emit) begin
               bank_in = !bank_ff;
               seq_in  = seq_ff + SEQ_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SETTLE;
         div_ff   <= '0;
         timer_ff <= '0;
         seq_ff   <= '0;
         angle_ff <= '0;
         bank_ff  <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            bank0_ff[i] <= '0;
            bank1_ff[i] <= '0;
         end
      end else if (fire) begin
         phase_ff <= phase_in;
         div_ff   <= div_in;
         timer_ff <= timer_in;
         seq_ff   <= seq_in;
         angle_ff <= angle_in;
         bank_ff  <= bank_in;
         if (!is_tick) begin
            for (int i = 0; i < NUM_CH; i++) begin
               if (bank_ff) bank1_ff[i] <= samp[i];
               else         bank0_ff[i] <= samp[i];
            end
         end
      end
   end

   always_comb begin
      result           = '0;
      result.angle_now = angle_in;
      if (run_act && emit) begin
         result.record_valid = 1'b1;
         result.record_index = seq_ff;
         result.record_mode  = (phase_ff == PH_ROTATE) ? MODE_ANGLE : MODE_NOISE;
         result.record_angle = angle_ff;
         result.rec_sin_a    = rd[0];
         result.rec_cos_a    = rd[1];
         result.rec_sin_b    = rd[2];
         result.rec_cos_b    = rd[3];
      end
   end

endmodule

// ===== hw/rtl/motor_angle_calibration_sequencer.sv =====
// a request beat moves from the input register into the result register, where it shows as rsp_valid
// throughput: one item per cycle while rsp_stall is low, input register and result register each hold one beat
// the sequencer state and sample banks update as an item moves into the result register
// reset (synchronous, active high) empties both stages, puts the phase in settle, clears
// timer, divider, sequence, angle, bank select and both sample banks, reloads registers
module motor_angle_calibration_sequencer #(
   parameter int TICKS_PER_CYCLE = macs_pkg::TICKS_PER_CYCLE_DEF,
   parameter int STEPS_PER_TURN  = macs_pkg::STEPS_PER_TURN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  macs_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output macs_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [macs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [macs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import macs_pkg::*;

   logic    item_valid;
   logic    out_free;
   logic    advance;
   req_type item;
   rsp_type result;

   assign advance = item_valid && out_free;

   macs_req_stage u_req (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   macs_core #(
      .TICKS_PER_CYCLE (TICKS_PER_CYCLE),
      .STEPS_PER_TURN  (STEPS_PER_TURN)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (advance),
      .item      (item),
      .result    (result)
   );

   macs_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // an item leaving the input register always lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced item did not reach result register");

   // the input register never drops a held item while the result side is blocked
   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      item_valid && !out_free |=> item_valid)
      else $error("held request lost while result side blocked");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.angle_now) < 32'(STEPS_PER_TURN)))
      else $error("commanded angle out of range");

   a_no_record_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.record_valid |->
         (rsp_data.record_index == '0) && (rsp_data.record_angle == '0) &&
         (rsp_data.record_mode == MODE_NOISE))
      else $error("record fields set without a record");

endmodule

// ===== tb/sv/motor_angle_calibration_sequencer_tb.sv =====
// self-checking testbench of the motor angle calibration sequencer
`timescale 1ns / 100ps

module motor_angle_calibration_sequencer_tb;
   import macs_pkg::*;

   localparam int unsigned ROT_MS_PER_PAIR = TICKS_PER_CYCLE_DEF * STEPS_PER_TURN_DEF;
   localparam logic [ANGLE_W-1:0] LAST_STEP = ANGLE_W'(STEPS_PER_TURN_DEF - 1);

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   motor_angle_calibration_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted sequencer state, mirrors the block from reset
   logic [MS_W-1:0]        cfg_settle = SETTLE_MS_RST;
   logic [MS_W-1:0]        cfg_noise  = NOISE_MS_RST;
   logic [PAIRS_W-1:0]     cfg_pairs  = POLE_PAIRS_RST;
   phase_type              cur_phase  = PH_SETTLE;
   logic [4:0]             tick_div   = '0;
   logic [TIMER_W-1:0]     ph_timer   = '0;
   logic [SEQ_W-1:0]       seq_num    = '0;
   logic [ANGLE_W-1:0]     angle_pos  = '0;
   logic                   bank_sel   = 1'b0;
   logic [SAMPLE_BITS-1:0] bank_data [2][NUM_CH] = '{default: '0};

   rsp_type pending_reports [$];

   int gap_pct    = 0;
   int stall_pct  = 0;
   int stall_hold = 0;
   int errors     = 0;
   int items_sent = 0;
   int results    = 0;
   int noise_recs = 0;
   int angle_recs = 0;
   int wraps      = 0;
   int csr_writes = 0;

   function automatic rsp_type sequencer_step(input req_type it);
      rsp_type            r;
      phase_type          nxt;
      logic               emit;
      logic               mode;
      logic [ANGLE_W-1:0] prior_angle;
      int unsigned        rot_limit;
      r = '0;
      if (it.command == CMD_SAMPLE) begin
         bank_data[bank_sel][0] = it.sin_a;
         bank_data[bank_sel][1] = it.cos_a;
         bank_data[bank_sel][2] = it.sin_b;
         bank_data[bank_sel][3] = it.cos_b;
         r.angle_now = angle_pos;
         return r;
      end
      tick_div = tick_div + 5'd1;
      if (ph_timer != TIMER_MAX) ph_timer = ph_timer + TIMER_W'(1);
      if (tick_div < TICKS_PER_CYCLE_DEF) begin
         r.angle_now = angle_pos;
         return r;
      end
      tick_div = '0;
      if (!it.run) begin
         cur_phase = PH_SETTLE;
         seq_num   = '0;
         ph_timer  = '0;
         angle_pos = '0;
         return r;
      end
      prior_angle = angle_pos;
      nxt         = cur_phase;
      emit        = 1'b0;
      mode        = MODE_NOISE;
      rot_limit   = ROT_MS_PER_PAIR * cfg_pairs;
      case (cur_phase)
         PH_SETTLE: begin
            if (ph_timer >= cfg_settle) nxt = PH_NOISE;
         end
         PH_NOISE: begin
            emit = 1'b1;
            if (ph_timer >= cfg_noise) nxt = PH_ROTATE;
         end
         PH_ROTATE: begin
            emit = 1'b1;
            mode = MODE_ANGLE;
            if (angle_pos >= LAST_STEP) angle_pos = '0;
            else angle_pos = angle_pos + ANGLE_W'(1);
            if (int'(ph_timer) >= rot_limit) nxt = PH_IDLE;
         end
         default: ;
      endcase
      if (nxt != cur_phase) begin
         cur_phase = nxt;
         ph_timer  = '0;
      end
      r.angle_now = angle_pos;
      if (emit) begin
         r.record_valid = 1'b1;
         r.record_index = seq_num;
         r.record_mode  = mode;
         r.record_angle = prior_angle;
         r.rec_sin_a    = bank_data[bank_sel][0];
         r.rec_cos_a    = bank_data[bank_sel][1];
         r.rec_sin_b    = bank_data[bank_sel][2];
         r.rec_cos_b    = bank_data[bank_sel][3];
         bank_sel       = ~bank_sel;
         seq_num        = seq_num + SEQ_W'(1);
      end
      return r;
   endfunction

   function automatic req_type sample_item(input logic [SAMPLE_BITS-1:0] a, b, c, d);
      req_type it;
      it.command = CMD_SAMPLE;
      it.run     = 1'($urandom_range(1));
      it.sin_a   = a;
      it.cos_a   = b;
      it.sin_b   = c;
      it.cos_b   = d;
      return it;
   endfunction

   function automatic req_type random_sample();
      return sample_item(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                         12'($urandom_range(4095)), 12'($urandom_range(4095)));
   endfunction

   // sample fields of a tick carry noise, the block must ignore them
   function automatic req_type tick_item(input logic run_bit);
      req_type it;
      it         = random_sample();
      it.command = CMD_TICK;
      it.run     = run_bit;
      return it;
   endfunction

   task automatic send_item(input req_type it);
      int gap;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      pending_reports.push_back(sequencer_step(it));
      items_sent++;
      if ($urandom_range(99) < gap_pct) begin
         gap = ($urandom_range(15) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_setting(input logic [CSR_IDX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      wait_drained();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_SETTLE_MS:  cfg_settle = value;
         CSR_NOISE_MS:   cfg_noise  = value;
         CSR_POLE_PAIRS: cfg_pairs  = value[PAIRS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic run_ticks(input int n_ticks, input int sample_pct, input int low_permille);
      int k;
      for (k = 0; k < n_ticks; k++) begin
         while ($urandom_range(99) < sample_pct) send_item(random_sample());
         send_item(tick_item($urandom_range(999) >= low_permille));
      end
   endtask

   // field extremes, run low on a non-acting tick, then run low on the acting tick
   task automatic test_directed();
      int k;
      gap_pct   = 0;
      stall_pct = 0;
      send_item(sample_item('1, '1, '1, '1));
      send_item(sample_item('0, '0, '0, '0));
      send_item(sample_item(12'haaa, 12'h555, 12'haaa, 12'h555));
      for (k = 1; k < TICKS_PER_CYCLE_DEF; k++) send_item(tick_item(k % 4 != 3));
      send_item(sample_item(12'h555, 12'haaa, 12'h555, 12'haaa));
      send_item(tick_item(1'b0));
      send_item(sample_item(12'h800, 12'h001, 12'h7ff, 12'hffe));
   endtask

   // register values out of reset: the long settle holds off every record
   task automatic test_default_settings();
      gap_pct   = 20;
      stall_pct = 20;
      run_ticks(TICKS_PER_CYCLE_DEF * 5, 10, 0);
   endtask

   // zero limits move on at the first acting tick, zero pairs end rotation at once
   task automatic test_zero_limits();
      write_setting(CSR_SETTLE_MS, '0);
      write_setting(CSR_NOISE_MS, '0);
      write_setting(CSR_POLE_PAIRS, 16'hff80);
      gap_pct   = 30;
      stall_pct = 30;
      run_ticks(TICKS_PER_CYCLE_DEF, 0, 1000);
      run_ticks(TICKS_PER_CYCLE_DEF * 4, 25, 0);
      run_ticks(TICKS_PER_CYCLE_DEF, 10, 1000);
   endtask

   // one full electrical turn with the angle wrapping, then idle
   task automatic test_full_turn();
      write_setting(CSR_SETTLE_MS, 16'd10);
      write_setting(CSR_NOISE_MS, 16'd16);
      write_setting(CSR_POLE_PAIRS, 16'd1);
      gap_pct   = 10;
      stall_pct = 10;
      run_ticks(TICKS_PER_CYCLE_DEF, 0, 1000);
      run_ticks(TICKS_PER_CYCLE_DEF * 103, 2, 0);
   endtask

   // pole pairs above range, upper bits of the write dropped, then all-ones limits
   task automatic test_register_extremes();
      write_setting(CSR_SETTLE_MS, '0);
      write_setting(CSR_NOISE_MS, '0);
      write_setting(CSR_POLE_PAIRS, 16'hffc1);
      gap_pct   = 25;
      stall_pct = 5;
      run_ticks(TICKS_PER_CYCLE_DEF, 0, 1000);
      run_ticks(TICKS_PER_CYCLE_DEF * 4, 30, 0);
      write_setting(CSR_SETTLE_MS, '1);
      write_setting(CSR_NOISE_MS, '1);
      write_setting(CSR_POLE_PAIRS, 16'h007f);
      gap_pct   = 5;
      stall_pct = 25;
      run_ticks(TICKS_PER_CYCLE_DEF * 3, 30, 0);
      run_ticks(TICKS_PER_CYCLE_DEF, 0, 1000);
      run_ticks(TICKS_PER_CYCLE_DEF * 2, 30, 0);
   endtask

   // mostly run-high tick streams with random samples and the odd run-low reset
   task automatic test_random_traffic();
      int round;
      int start;
      for (round = 0; round < 4; round++) begin
         write_setting(CSR_SETTLE_MS, ($urandom_range(7) == 0) ?
                       16'($urandom_range(65535)) : 16'($urandom_range(100)));
         write_setting(CSR_NOISE_MS, ($urandom_range(7) == 0) ?
                       16'($urandom_range(65535)) : 16'($urandom_range(100)));
         write_setting(CSR_POLE_PAIRS, 16'($urandom_range(2)));
         case (round)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 50; stall_pct = 10; end
            2: begin gap_pct = 10; stall_pct = 50; end
            default: begin gap_pct = 30; stall_pct = 30; end
         endcase
         start = items_sent;
         while (items_sent - start < 50) begin
            if ($urandom_range(99) < 30) send_item(random_sample());
            else send_item(tick_item($urandom_range(999) >= 20));
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // result side: compare each beat with the oldest prediction, stall at random
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         results++;
         if (pending_reports.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %p", $time, rsp_data);
            errors++;
         end else begin
            want = pending_reports.pop_front();
            check_field("angle_now", 32'(want.angle_now), 32'(rsp_data.angle_now));
            check_field("record_valid", 32'(want.record_valid),
                        32'(rsp_data.record_valid));
            check_field("record_index", want.record_index, rsp_data.record_index);
            check_field("record_mode", 32'(want.record_mode), 32'(rsp_data.record_mode));
            check_field("record_angle", 32'(want.record_angle),
                        32'(rsp_data.record_angle));
            check_field("rec_sin_a", 32'(want.rec_sin_a), 32'(rsp_data.rec_sin_a));
            check_field("rec_cos_a", 32'(want.rec_cos_a), 32'(rsp_data.rec_cos_a));
            check_field("rec_sin_b", 32'(want.rec_sin_b), 32'(rsp_data.rec_sin_b));
            check_field("rec_cos_b", 32'(want.rec_cos_b), 32'(rsp_data.rec_cos_b));
            if (want.record_valid && want.record_mode == MODE_NOISE) noise_recs++;
            if (want.record_valid && want.record_mode == MODE_ANGLE) begin
               angle_recs++;
               if (want.record_angle == LAST_STEP) wraps++;
            end
         end
      end
      if (stall_hold > 0) begin
         stall_hold--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(99) < stall_pct) begin
         stall_hold = ($urandom_range(15) == 0) ? $urandom_range(40, 8) : $urandom_range(2, 0);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_default_settings();
      test_zero_limits();
      test_full_turn();
      test_register_extremes();
      test_random_traffic();
      req_valid <= 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      $display("%0d items in, %0d results checked, %0d register writes",
               items_sent, results, csr_writes);
      $display("%0d noise records, %0d angle records, %0d angle wraps",
               noise_recs, angle_recs, wraps);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/macs_pkg.sv
hw/rtl/macs_req_stage.sv
hw/rtl/macs_rsp_stage.sv
hw/rtl/macs_core.sv
hw/rtl/motor_angle_calibration_sequencer.sv
tb/sv/motor_angle_calibration_sequencer_tb.sv
